// ===== hdl/brb_pkg.sv =====
// Shared constants and types for the byte ring buffer.
package brb_pkg;

  // Store size in bytes; a power of two, at least BANKS.
  localparam int unsigned DEPTH          = 4096;
  localparam int unsigned BYTES_PER_ITEM = 8;

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned IDX_W  = ADDR_W + 1;
  localparam int unsigned CNT_W  = IDX_W;

  // The store is split into byte banks so that a whole item touches each bank at most once.
  localparam int unsigned BANKS  = 8;
  localparam int unsigned BANK_W = $clog2(BANKS);
  localparam int unsigned ROWS   = DEPTH / BANKS;
  localparam int unsigned ROW_W  = $clog2(ROWS);

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned REGION_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 3'd0,
    OP_PEEK     = 3'd1,
    OP_FREE_Q   = 3'd2,
    OP_FILLED_Q = 3'd3,
    OP_PRODUCE  = 3'd4,
    OP_CONSUME  = 3'd5
  } op_e;

endpackage

// ===== hdl/brb_ram.sv =====
// Generic single-port RAM with a registered read.
module brb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/byte_ring_buffer.sv =====
// Top level of the power-of-two circular byte buffer.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ----------------------------------------
//  command   in         start_i, busy_o           operation_i, count_i, write_data_i
//  result    out        done_o (one-cycle strobe) status_o, regions_o, first_offset_o,
//                                                 first_size_o, second_size_o, read_data_o,
//                                                 bytes_available_o, bytes_free_o
//
// An item is taken when start_i is high and busy_o is low. Its result appears in the next
// cycle with done_o high for exactly that cycle, during which busy_o is high, so no new
// item is taken in the result cycle. The result timing comes from the registered read
// of the byte banks: the banks are addressed in the accept cycle and the peeked bytes
// come out in the result cycle. Reset clears both indices; the store itself is not
// cleared and holds unknown bytes until written. The receiver cannot stall results.
module byte_ring_buffer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [brb_pkg::OP_W-1:0]      operation_i,
  input  logic [brb_pkg::CNT_W-1:0]     count_i,
  input  logic [brb_pkg::DATA_W-1:0]    write_data_i,
  output logic                          done_o,
  output logic                          status_o,
  output logic [brb_pkg::REGION_W-1:0]  regions_o,
  output logic [brb_pkg::ADDR_W-1:0]    first_offset_o,
  output logic [brb_pkg::CNT_W-1:0]     first_size_o,
  output logic [brb_pkg::CNT_W-1:0]     second_size_o,
  output logic [brb_pkg::DATA_W-1:0]    read_data_o,
  output logic [brb_pkg::CNT_W-1:0]     bytes_available_o,
  output logic [brb_pkg::CNT_W-1:0]     bytes_free_o
);
  import brb_pkg::*;

  // Free-running indices, one bit wider than the store address.
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             done_q;

  // Result fields held for the strobe cycle.
  logic                status_q, status_d;
  logic [REGION_W-1:0] regions_q, regions_d;
  logic [ADDR_W-1:0]   first_offset_q, first_offset_d;
  logic [CNT_W-1:0]    first_size_q, first_size_d;
  logic [CNT_W-1:0]    second_size_q, second_size_d;
  logic                peek_q, peek_d;
  logic [BANK_W:0]     peek_cnt_q;
  logic [BANK_W-1:0]   off_lo_q;

  logic             accept;
  op_e              op;
  logic [CNT_W-1:0] filled;
  logic [CNT_W-1:0] free;
  logic [IDX_W-1:0] span_idx;
  logic [ADDR_W-1:0] span_off;
  logic [CNT_W-1:0] room;
  logic             too_long;
  logic             over_free;
  logic             over_filled;
  logic             span_on;
  logic             wr_go;
  logic [CNT_W-1:0] wr_add;
  logic [CNT_W-1:0] rd_add;

  logic [BANK_W-1:0] bank_k     [BANKS];
  logic [ROW_W-1:0]  bank_addr  [BANKS];
  logic              bank_we    [BANKS];
  logic [7:0]        bank_wdata [BANKS];
  logic [7:0]        bank_rdata [BANKS];

  assign accept = start_i && !done_q;
  assign op     = op_e'(operation_i);

  assign filled = wr_idx_q - rd_idx_q;
  assign free   = CNT_W'(DEPTH) - filled;

  // Writes and the free query look at the span at the write index, the rest at the read index.
  assign span_idx = (op == OP_WRITE || op == OP_FREE_Q) ? wr_idx_q : rd_idx_q;
  assign span_off = span_idx[ADDR_W-1:0];
  assign room     = CNT_W'(DEPTH) - {1'b0, span_off};

  assign too_long    = count_i > CNT_W'(BYTES_PER_ITEM);
  assign over_free   = count_i > free;
  assign over_filled = count_i > filled;

  always_comb begin
    status_d = 1'b0;
    span_on  = 1'b0;
    wr_go    = 1'b0;
    peek_d   = 1'b0;
    wr_add   = '0;
    rd_add   = '0;
    unique case (op)
      OP_WRITE: begin
        if (too_long || over_free) begin
          status_d = 1'b1;
        end else begin
          span_on = 1'b1;
          wr_go   = 1'b1;
          wr_add  = count_i;
        end
      end
      OP_PEEK: begin
        if (too_long || over_filled) begin
          status_d = 1'b1;
        end else begin
          span_on = 1'b1;
          peek_d  = 1'b1;
        end
      end
      OP_FREE_Q: begin
        status_d = over_free;
        span_on  = !over_free;
      end
      OP_FILLED_Q: begin
        status_d = over_filled;
        span_on  = !over_filled;
      end
      OP_PRODUCE: begin
        // Clamp an overrun to the free space.
        status_d = over_free;
        wr_add   = over_free ? free : count_i;
      end
      OP_CONSUME: begin
        status_d = over_filled;
        rd_add   = over_filled ? filled : count_i;
      end
      default: begin
        status_d = 1'b1;
      end
    endcase
  end

  // Split the span into the part up to the end of the store and the wrapped part.
  always_comb begin
    regions_d      = '0;
    first_offset_d = '0;
    first_size_d   = '0;
    second_size_d  = '0;
    if (span_on) begin
      first_offset_d = span_off;
      if (room >= count_i) begin
        regions_d    = REGION_W'(1);
        first_size_d = count_i;
      end else begin
        regions_d     = REGION_W'(2);
        first_size_d  = room;
        second_size_d = count_i - room;
      end
    end
  end

  assign wr_idx_d = wr_idx_q + wr_add;
  assign rd_idx_d = rd_idx_q + rd_add;

  // Byte k of the span lands in bank (offset + k) mod BANKS. Banks below the starting
  // bank hold the bytes that spill into the next row.
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      bank_k[b]     = BANK_W'(b) - span_off[BANK_W-1:0];
      bank_addr[b]  = span_off[ADDR_W-1:BANK_W]
                    + ROW_W'(BANK_W'(b) < span_off[BANK_W-1:0]);
      bank_we[b]    = accept && wr_go && ({1'b0, bank_k[b]} < count_i[BANK_W:0]);
      bank_wdata[b] = write_data_i[8*bank_k[b] +: 8];
    end
  end

  for (genvar g = 0; g < BANKS; g++) begin : g_bank
    brb_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[g]),
      .addr_i  (bank_addr[g]),
      .wdata_i (bank_wdata[g]),
      .rdata_o (bank_rdata[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q       <= status_d;
      regions_q      <= regions_d;
      first_offset_q <= first_offset_d;
      first_size_q   <= first_size_d;
      second_size_q  <= second_size_d;
      peek_q         <= peek_d;
      peek_cnt_q     <= count_i[BANK_W:0];
      off_lo_q       <= span_off[BANK_W-1:0];
    end
  end

  // For a peek, rotate the bank outputs back into byte order and drop bytes past the count.
  always_comb begin
    logic [BANK_W-1:0] bsel;
    read_data_o = '0;
    for (int k = 0; k < BYTES_PER_ITEM; k++) begin
      bsel = off_lo_q + BANK_W'(k);
      if (peek_q && (BANK_W'(k) < peek_cnt_q)) begin
        read_data_o[8*k +: 8] = bank_rdata[bsel];
      end
    end
  end

  assign busy_o            = done_q;
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign regions_o         = regions_q;
  assign first_offset_o    = first_offset_q;
  assign first_size_o      = first_size_q;
  assign second_size_o     = second_size_q;
  // The indices already hold their new values during the result cycle.
  assign bytes_available_o = filled;
  assign bytes_free_o      = free;

endmodule

// ===== hdl/brb_checker.sv =====
// Port-level assertions for the byte ring buffer, bound to the top level.
module brb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic [brb_pkg::CNT_W-1:0]     count_i,
  input logic                          done_o,
  input logic                          status_o,
  input logic [brb_pkg::REGION_W-1:0]  regions_o,
  input logic [brb_pkg::CNT_W-1:0]     first_size_o,
  input logic [brb_pkg::CNT_W-1:0]     second_size_o,
  input logic [brb_pkg::CNT_W-1:0]     bytes_available_o,
  input logic [brb_pkg::CNT_W-1:0]     bytes_free_o
);
  import brb_pkg::*;

  // Every accepted item gives its result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted item gave no result in the next cycle");

  // One item, one result.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  // Filled and free bytes add up to the store size in every result cycle.
  a_counts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ({1'b0, bytes_available_o} + {1'b0, bytes_free_o}) == (CNT_W + 1)'(DEPTH))
    else $error("available and free counts do not add up to the store size");

  // The regions of a reported span cover exactly the requested count.
  a_span_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && regions_o != '0) |->
      ({1'b0, first_size_o} + {1'b0, second_size_o}) == {1'b0, $past(count_i)})
    else $error("region sizes do not add up to the requested count");

  // A reported span never goes with a refusal.
  a_refused_no_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (regions_o == '0))
    else $error("refused or clamped item reported regions");

endmodule

bind byte_ring_buffer brb_checker u_brb_checker (.*);
